>>> hw/rtl/bclf_pkg.sv
// ----------------------------------------------------------------------------
// bclf_pkg - battery charge level filter shared definitions
// Word types, sequencer states, register indexes and the fixed discharge
// curve that maps millivolts to charge percent.
// ----------------------------------------------------------------------------
package bclf_pkg;

   localparam int ADC_BITS      = 14;
   localparam int SAMPLES_MAX   = 64;
   localparam int TABLE_ENTRIES = 21;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int SUM_W         = 20;
   localparam int VOLT_W        = 17;
   localparam int PCT_W         = 7;
   localparam int MV_W          = 13;
   localparam int RATIO_W       = 4;
   localparam int CREDIT_W      = 4;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 8;

   localparam logic [VOLT_W-1:0]   VOLT_MAX   = '1;
   localparam logic [SUM_W-1:0]    SUM_MAX    = '1;
   localparam logic [CREDIT_W-1:0] CREDIT_MAX = 4'd10;
   localparam logic [PCT_W-1:0]    PCT_RESET  = 7'd50;

   localparam logic [RATIO_W-1:0] DIVIDER_RATIO_RESET      = 4'd2;
   localparam logic [PCT_W-1:0]   LOW_THRESHOLD_RESET      = 7'd20;
   localparam logic [PCT_W-1:0]   CRITICAL_THRESHOLD_RESET = 7'd5;

   // Discharge curve, full charge first
   localparam logic [MV_W-1:0] LUT_MV [TABLE_ENTRIES] = '{
      13'd4200, 13'd4150, 13'd4110, 13'd4080, 13'd4040, 13'd4000, 13'd3960,
      13'd3920, 13'd3880, 13'd3840, 13'd3800, 13'd3760, 13'd3720, 13'd3680,
      13'd3640, 13'd3600, 13'd3560, 13'd3500, 13'd3400, 13'd3250, 13'd3000
   };
   localparam logic [PCT_W-1:0] LUT_PCT [TABLE_ENTRIES] = '{
      7'd100, 7'd95, 7'd90, 7'd85, 7'd80, 7'd75, 7'd70,
      7'd65,  7'd60, 7'd55, 7'd50, 7'd45, 7'd40, 7'd35,
      7'd30,  7'd25, 7'd20, 7'd15, 7'd10, 7'd5,  7'd0
   };

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DIVIDER_RATIO      = 3'd0,
      CSR_LOW_THRESHOLD      = 3'd1,
      CSR_CRITICAL_THRESHOLD = 3'd2,
      CSR_SHUTDOWN_ENABLE    = 3'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_AVG_DIV,
      ST_SCALE,
      ST_SEARCH,
      ST_INTERP_DIV,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic                mode;
      logic [ADC_BITS-1:0] adc_millivolts;
      logic                sample_valid;
      logic                last_sample;
      logic                charging;
      logic                charge_done;
   } req_type;

   typedef struct packed {
      logic [PCT_W-1:0]  percent;
      logic [PCT_W-1:0]  raw_percent;
      logic [VOLT_W-1:0] battery_mv;
      logic              battery_low;
      logic              battery_critical;
      logic              low_changed;
      logic              shutdown_request;
      logic              sample_failed;
   } rsp_type;

endpackage

>>> hw/rtl/battery_charge_level_filter_top.sv
// ----------------------------------------------------------------------------
// battery_charge_level_filter_top - battery charge level filter
// Averages ADC samples over a period, maps the voltage onto the discharge
// curve and filters the resulting charge percent.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ carries one ADC sample word per handshake. Valid samples are summed
//    and counted; a word with last_sample set closes the period.
//  - A word without last_sample is accepted in the idle state and yields no result.
//  - A closing word starts the period-end sequence, during which req_ready is
//    low: the average division (one quotient bit a cycle on the shared
//    restoring divider), the divider-ratio scaling, the curve search (one
//    segment a cycle), the interpolation division (on the same divider,
//    only for a voltage inside a segment) and the commit. A period with no
//    valid sample goes straight to the commit.
//  - rsp_ carries one result word per closed period from an output register.
//    Sample words of the next period are taken while that word waits; only
//    the commit of the next period holds until rsp_ready takes it.
//  - csr_ writes a register by index at any handshake; csr_ready is always
//    high. Unknown indexes are ignored. Write only while the block is idle.
//  - Synchronous reset restores the register defaults, 50 % cached charge,
//    full change credit and an empty accumulator. There is no clearing pass.
// ----------------------------------------------------------------------------
module battery_charge_level_filter_top #(
   parameter int SAMPLES_MAX = bclf_pkg::SAMPLES_MAX
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  bclf_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output bclf_pkg::rsp_type                  rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bclf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bclf_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int CNT_W = $clog2(SAMPLES_MAX + 1);
   localparam int DVD_W = bclf_pkg::SUM_W;        // dividend / quotient width
   localparam int DVS_W = bclf_pkg::MV_W;         // divisor / remainder width
   localparam int STEP_W = $clog2(DVD_W);
   localparam int IDX_W = bclf_pkg::IDX_W;
   localparam int PCT_W = bclf_pkg::PCT_W;
   localparam int VOLT_W = bclf_pkg::VOLT_W;
   localparam int MV_W = bclf_pkg::MV_W;
   localparam int LAST = bclf_pkg::TABLE_ENTRIES - 1;

   // ---------------------------------------------------------------- state
   bclf_pkg::state_type state_ff, state_in;

   // configuration registers
   logic [bclf_pkg::RATIO_W-1:0] ratio_ff, ratio_in;
   logic [PCT_W-1:0]             low_thr_ff, low_thr_in;
   logic [PCT_W-1:0]             crit_thr_ff, crit_thr_in;
   logic                         shut_en_ff, shut_en_in;

   // accumulator and cached battery state
   logic [DVD_W-1:0]                sum_ff, sum_in;
   logic [CNT_W-1:0]                cnt_ff, cnt_in;
   logic [PCT_W-1:0]                cpct_ff, cpct_in;
   logic [VOLT_W-1:0]               cvolt_ff, cvolt_in;
   logic [bclf_pkg::CREDIT_W-1:0]   credit_ff, credit_in;
   logic                            low_ff, low_in;
   logic                            crit_ff, crit_in;

   // period-end working registers
   logic                mode_ff, mode_in;
   logic                chg_ff, chg_in;
   logic                done_ff, done_in;
   logic                failed_ff, failed_in;
   logic [VOLT_W-1:0]   volt_ff, volt_in;
   logic [PCT_W-1:0]    raw_ff, raw_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;

   // shared restoring divider
   logic [DVD_W-1:0]    quo_ff, quo_in;
   logic [DVS_W-1:0]    rem_ff, rem_in;
   logic [DVS_W-1:0]    dvs_ff, dvs_in;
   logic [STEP_W-1:0]   step_ff, step_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   bclf_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   // ---------------------------------------------------------------- helpers
   logic                req_fire;
   logic                commit_ok;
   logic [DVD_W:0]      sum_ext;
   logic [DVD_W-1:0]    sum_acc;
   logic [CNT_W-1:0]    cnt_acc;
   logic                take_sample;

   logic [DVS_W:0]      div_trial;
   logic [DVS_W:0]      div_diff;
   logic                div_bit;
   logic [DVD_W-1:0]    div_quo;
   logic [DVS_W-1:0]    div_rem;
   logic                div_last;

   logic [DVD_W+bclf_pkg::RATIO_W-1:0] scaled;

   logic [IDX_W-1:0]    idx_nxt;
   logic [MV_W-1:0]     seg_hi, seg_lo, seg_range;
   logic [PCT_W-1:0]    pct_hi, pct_lo;
   logic                above_top, below_bottom, in_seg;
   logic [VOLT_W-1:0]   volt_off;
   logic [DVD_W-1:0]    interp_num;

   logic                up_ok;
   logic [PCT_W-1:0]    f_clamp, f_new, diff, act;
   logic [bclf_pkg::CREDIT_W-1:0] credit_inc, credit_new;
   logic [PCT_W+3:0]    used;
   logic                low_new, crit_new;

   assign req_fire  = req_valid && req_ready;
   assign commit_ok = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == bclf_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // accumulate a sample, saturating the sum; drop samples past the cap
   assign take_sample = req_data.sample_valid && (cnt_ff < CNT_W'(SAMPLES_MAX));
   assign sum_ext = {1'b0, sum_ff} + (DVD_W+1)'(req_data.adc_millivolts);
   assign sum_acc = !take_sample ? sum_ff :
                    (sum_ext[DVD_W] ? bclf_pkg::SUM_MAX : sum_ext[DVD_W-1:0]);
   assign cnt_acc = take_sample ? cnt_ff + CNT_W'(1) : cnt_ff;

   // one restoring division step: shift in the next dividend bit, subtract
   assign div_trial = {rem_ff, quo_ff[DVD_W-1]};
   assign div_diff  = div_trial - {1'b0, dvs_ff};
   assign div_bit   = !div_diff[DVS_W];
   assign div_quo   = {quo_ff[DVD_W-2:0], div_bit};
   assign div_rem   = div_bit ? div_diff[DVS_W-1:0] : div_trial[DVS_W-1:0];
   assign div_last  = (step_ff == '0);

   // scale the average by the divider ratio
   assign scaled = quo_ff * ratio_ff;

   // curve segment under test
   assign idx_nxt      = idx_ff + IDX_W'(1);
   assign seg_hi       = bclf_pkg::LUT_MV[idx_ff];
   assign seg_lo       = bclf_pkg::LUT_MV[idx_nxt];
   assign pct_hi       = bclf_pkg::LUT_PCT[idx_ff];
   assign pct_lo       = bclf_pkg::LUT_PCT[idx_nxt];
   assign seg_range    = seg_hi - seg_lo;
   assign above_top    = volt_ff >= VOLT_W'(bclf_pkg::LUT_MV[0]);
   assign below_bottom = volt_ff <= VOLT_W'(bclf_pkg::LUT_MV[LAST]);
   assign in_seg       = (volt_ff <= VOLT_W'(seg_hi)) && (volt_ff >= VOLT_W'(seg_lo));
   assign volt_off     = volt_ff - VOLT_W'(seg_lo);
   assign interp_num   = DVD_W'((pct_hi - pct_lo) * volt_off[MV_W-1:0]);

   // periodic filter: direction clamp, then credit limit
   always_comb begin
      up_ok = chg_ff || done_ff;
      if (up_ok && raw_ff < cpct_ff) begin
         f_clamp = cpct_ff;
      end else if (!up_ok && raw_ff > cpct_ff) begin
         f_clamp = cpct_ff;
      end else begin
         f_clamp = raw_ff;
      end
      credit_inc = (credit_ff < bclf_pkg::CREDIT_MAX) ? credit_ff + 4'd1 : credit_ff;
      diff = (f_clamp > cpct_ff) ? f_clamp - cpct_ff : cpct_ff - f_clamp;
      // whole percent allowed is credit / 10, and credit never exceeds 10
      act = (credit_inc >= bclf_pkg::CREDIT_MAX && diff != '0) ? PCT_W'(1) : '0;
      used = (PCT_W+4)'(act) * (PCT_W+4)'(10);
      if (f_clamp == cpct_ff) begin
         f_new      = f_clamp;
         credit_new = credit_inc;
      end else begin
         f_new = (f_clamp > cpct_ff) ? cpct_ff + act : cpct_ff - act;
         credit_new = (used >= (PCT_W+4)'(credit_inc)) ? '0
                    : credit_inc - bclf_pkg::CREDIT_W'(used);
      end
      low_new  = f_new <= low_thr_ff;
      crit_new = f_new <= crit_thr_ff;
   end

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bclf_pkg::ST_IDLE: begin
            if (req_fire && req_data.last_sample) begin
               state_in = (cnt_acc == '0) ? bclf_pkg::ST_COMMIT : bclf_pkg::ST_AVG_DIV;
            end
         end
         bclf_pkg::ST_AVG_DIV: begin
            if (div_last) begin
               state_in = bclf_pkg::ST_SCALE;
            end
         end
         bclf_pkg::ST_SCALE: begin
            state_in = bclf_pkg::ST_SEARCH;
         end
         bclf_pkg::ST_SEARCH: begin
            if (above_top || below_bottom || (in_seg && seg_range == '0)) begin
               state_in = bclf_pkg::ST_COMMIT;
            end else if (in_seg) begin
               state_in = bclf_pkg::ST_INTERP_DIV;
            end
         end
         bclf_pkg::ST_INTERP_DIV: begin
            if (div_last) begin
               state_in = bclf_pkg::ST_COMMIT;
            end
         end
         bclf_pkg::ST_COMMIT: begin
            if (commit_ok) begin
               state_in = bclf_pkg::ST_IDLE;
            end
         end
         default: state_in = bclf_pkg::ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- datapath
   always_comb begin
      ratio_in     = ratio_ff;
      low_thr_in   = low_thr_ff;
      crit_thr_in  = crit_thr_ff;
      shut_en_in   = shut_en_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      cpct_in      = cpct_ff;
      cvolt_in     = cvolt_ff;
      credit_in    = credit_ff;
      low_in       = low_ff;
      crit_in      = crit_ff;
      mode_in      = mode_ff;
      chg_in       = chg_ff;
      done_in      = done_ff;
      failed_in    = failed_ff;
      volt_in      = volt_ff;
      raw_in       = raw_ff;
      idx_in       = idx_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      // register writes
      if (csr_valid) begin
         unique case (csr_index)
            bclf_pkg::CSR_DIVIDER_RATIO:
               ratio_in = csr_wdata[bclf_pkg::RATIO_W-1:0];
            bclf_pkg::CSR_LOW_THRESHOLD:
               low_thr_in = csr_wdata[PCT_W-1:0];
            bclf_pkg::CSR_CRITICAL_THRESHOLD:
               crit_thr_in = csr_wdata[PCT_W-1:0];
            bclf_pkg::CSR_SHUTDOWN_ENABLE:
               shut_en_in = csr_wdata[0];
            default: ;
         endcase
      end

      unique case (state_ff)
         bclf_pkg::ST_IDLE: begin
            if (req_fire) begin
               sum_in = sum_acc;
               cnt_in = cnt_acc;
               if (req_data.last_sample) begin
                  // latch the period status, hand the sum to the divider,
                  // and clear the accumulator for the next period
                  mode_in   = req_data.mode;
                  chg_in    = req_data.charging;
                  done_in   = req_data.charge_done;
                  failed_in = (cnt_acc == '0);
                  raw_in    = '0;
                  idx_in    = '0;
                  quo_in    = sum_acc;
                  rem_in    = '0;
                  dvs_in    = {{(DVS_W-CNT_W){1'b0}}, cnt_acc};
                  step_in   = STEP_W'(DVD_W - 1);
                  sum_in    = '0;
                  cnt_in    = '0;
               end
            end
         end
         bclf_pkg::ST_AVG_DIV: begin
            quo_in  = div_quo;
            rem_in  = div_rem;
            step_in = step_ff - STEP_W'(1);
         end
         bclf_pkg::ST_SCALE: begin
            volt_in = (scaled > ($bits(scaled))'(bclf_pkg::VOLT_MAX))
                    ? bclf_pkg::VOLT_MAX : scaled[VOLT_W-1:0];
         end
         bclf_pkg::ST_SEARCH: begin
            if (above_top) begin
               raw_in = bclf_pkg::LUT_PCT[0];
            end else if (below_bottom) begin
               raw_in = bclf_pkg::LUT_PCT[LAST];
            end else if (in_seg) begin
               if (seg_range == '0) begin
                  raw_in = pct_hi;
               end else begin
                  quo_in  = interp_num;
                  rem_in  = '0;
                  dvs_in  = seg_range;
                  step_in = STEP_W'(DVD_W - 1);
               end
            end else begin
               idx_in = idx_nxt;
            end
         end
         bclf_pkg::ST_INTERP_DIV: begin
            quo_in  = div_quo;
            rem_in  = div_rem;
            step_in = step_ff - STEP_W'(1);
            if (div_last) begin
               raw_in = pct_lo + div_quo[PCT_W-1:0];
            end
         end
         bclf_pkg::ST_COMMIT: begin
            // hold until the previous result word has left
            if (commit_ok) begin
               rsp_valid_in                 = 1'b1;
               rsp_data_in.raw_percent      = raw_ff;
               rsp_data_in.sample_failed    = failed_ff;
               rsp_data_in.low_changed      = 1'b0;
               rsp_data_in.shutdown_request = 1'b0;
               rsp_data_in.percent          = cpct_ff;
               rsp_data_in.battery_mv       = cvolt_ff;
               rsp_data_in.battery_low      = low_ff;
               rsp_data_in.battery_critical = crit_ff;
               if (!failed_ff && mode_ff) begin
                  // initial load: take the curve value as is
                  cvolt_in                = volt_ff;
                  cpct_in                 = raw_ff;
                  credit_in               = bclf_pkg::CREDIT_MAX;
                  rsp_data_in.percent     = raw_ff;
                  rsp_data_in.battery_mv  = volt_ff;
               end else if (!failed_ff) begin
                  cvolt_in  = volt_ff;
                  cpct_in   = f_new;
                  credit_in = credit_new;
                  low_in    = low_new;
                  crit_in   = crit_new;
                  rsp_data_in.percent          = f_new;
                  rsp_data_in.battery_mv       = volt_ff;
                  rsp_data_in.battery_low      = low_new;
                  rsp_data_in.battery_critical = crit_new;
                  rsp_data_in.low_changed      = low_new != low_ff;
                  rsp_data_in.shutdown_request = crit_new && !chg_ff && shut_en_ff;
               end
            end
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bclf_pkg::ST_IDLE;
         ratio_ff     <= bclf_pkg::DIVIDER_RATIO_RESET;
         low_thr_ff   <= bclf_pkg::LOW_THRESHOLD_RESET;
         crit_thr_ff  <= bclf_pkg::CRITICAL_THRESHOLD_RESET;
         shut_en_ff   <= 1'b0;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         cpct_ff      <= bclf_pkg::PCT_RESET;
         cvolt_ff     <= '0;
         credit_ff    <= bclf_pkg::CREDIT_MAX;
         low_ff       <= 1'b0;
         crit_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ratio_ff     <= ratio_in;
         low_thr_ff   <= low_thr_in;
         crit_thr_ff  <= crit_thr_in;
         shut_en_ff   <= shut_en_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         cpct_ff      <= cpct_in;
         cvolt_ff     <= cvolt_in;
         credit_ff    <= credit_in;
         low_ff       <= low_in;
         crit_ff      <= crit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      chg_ff      <= chg_in;
      done_ff     <= done_in;
      failed_ff   <= failed_in;
      volt_ff     <= volt_in;
      raw_ff      <= raw_in;
      idx_ff      <= idx_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      dvs_ff      <= dvs_in;
      step_ff     <= step_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

>>> tb/battery_charge_level_filter_top_test.sv
// ----------------------------------------------------------------------------
// battery_charge_level_filter_top_test - charge level filter testbench
// Feeds ADC sample words through the request channel in random bursts and
// checks every result word against an in-bench model of the averaging,
// discharge-curve lookup, charge filter and flag logic. A short table of
// hand-picked words comes first, then eight register settings each carry a
// stretch of randomly shaped monitoring periods.
// ----------------------------------------------------------------------------
module battery_charge_level_filter_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          CLOCK_HALF       = 6;
   localparam int          RESET_CYCLES     = 5;
   localparam int          SETTLE_CYCLES    = 70;   // beyond the longest period end
   localparam int          TAIL_CYCLES      = 80;
   localparam int          HOLD_OFF_CYCLES  = 600;
   localparam int unsigned CYCLE_LIMIT      = 1_000_000;
   localparam int          PHASES           = 8;
   localparam int          WORDS_PER_PHASE  = 150;
   localparam int          CSR_FIRST_UNUSED = 4;

   // Accumulator and voltage limits of the filter
   localparam int unsigned ACC_DEPTH   = 64;
   localparam int unsigned ACC_SUM_MAX = 20'hFFFFF;
   localparam int unsigned MV_CEILING  = 131071;
   localparam int unsigned CREDIT_FULL = 10;

   // Discharge curve, full charge first; each step down is 5 percent
   localparam int unsigned CURVE_POINTS = 21;
   localparam int unsigned CURVE_MV [CURVE_POINTS] = '{
      4200, 4150, 4110, 4080, 4040, 4000, 3960, 3920, 3880, 3840, 3800,
      3760, 3720, 3680, 3640, 3600, 3560, 3500, 3400, 3250, 3000
   };

   typedef struct packed {
      bclf_pkg::req_type word;
      logic              typed;     // expected result written out below
      bclf_pkg::rsp_type reading;
   } stim_row_type;

   typedef struct packed {
      logic [bclf_pkg::RATIO_W-1:0] ratio;
      logic [bclf_pkg::PCT_W-1:0]   low_pct;
      logic [bclf_pkg::PCT_W-1:0]   crit_pct;
      logic                         shut_en;
   } csr_setting_type;

   typedef enum {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_TOGGLE} stall_style_type;

   // Hand-picked words. Only the first few carry a written-out reading:
   // the empty period straight after reset and initial loads at the extremes.
   localparam int DIRECTED_COUNT = 21;
   localparam stim_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      // no valid sample after reset: state kept, sample_failed raised
      '{'{1'b0, 14'd0,     1'b0, 1'b1, 1'b0, 1'b0}, 1'b1,
        '{7'd50, 7'd0, 17'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}},
      // initial load at the top of the curve
      '{'{1'b1, 14'd2100,  1'b1, 1'b1, 1'b0, 1'b0}, 1'b1,
        '{7'd100, 7'd100, 17'd4200, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
      // initial load with the largest reading
      '{'{1'b1, 14'd16383, 1'b1, 1'b1, 1'b0, 1'b0}, 1'b1,
        '{7'd100, 7'd100, 17'd32766, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
      // initial load at zero volts, flags left alone
      '{'{1'b1, 14'd0,     1'b1, 1'b1, 1'b0, 1'b0}, 1'b1,
        '{7'd0, 7'd0, 17'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
      // control fields on a non-closing word must be ignored
      '{'{1'b1, 14'd2100,  1'b1, 1'b0, 1'b1, 1'b1}, 1'b0, '0},
      '{'{1'b1, 14'd16383, 1'b0, 1'b0, 1'b1, 1'b1}, 1'b0, '0},
      // discharging may not rise, then charging and charge_done may
      '{'{1'b0, 14'd2100,  1'b1, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
      '{'{1'b0, 14'd2100,  1'b1, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
      '{'{1'b0, 14'd2100,  1'b1, 1'b1, 1'b0, 1'b1}, 1'b0, '0},
      // load near empty, then a critical periodic period
      '{'{1'b1, 14'd1600,  1'b1, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
      '{'{1'b0, 14'd1600,  1'b1, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
      // three-word period with one invalid sample
      '{'{1'b0, 14'd2099,  1'b1, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
      '{'{1'b0, 14'd2101,  1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
      '{'{1'b0, 14'd2099,  1'b1, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
      // exact curve points
      '{'{1'b0, 14'd1780,  1'b1, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
      '{'{1'b0, 14'd1750,  1'b1, 1'b1, 1'b0, 1'b1}, 1'b0, '0},
      // empty period in initial mode
      '{'{1'b1, 14'd100,   1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
      '{'{1'b1, 14'd100,   1'b0, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
      '{'{1'b0, 14'd16383, 1'b1, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
      // just below the bottom of the curve
      '{'{1'b1, 14'd1499,  1'b1, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
      '{'{1'b0, 14'd1625,  1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, '0}
   };

   // Fixed settings first (extremes among them), random ones after
   localparam int FIXED_SETTINGS = 5;
   localparam csr_setting_type PHASE_SETTINGS [FIXED_SETTINGS] = '{
      '{4'd2,  7'd20,  7'd5,   1'b1},
      '{4'd1,  7'd0,   7'd0,   1'b1},
      '{4'd8,  7'd100, 7'd100, 1'b0},
      '{4'd15, 7'd127, 7'd127, 1'b1},   // voltage clips, thresholds above 100
      '{4'd0,  7'd50,  7'd30,  1'b1}    // zero ratio gives zero volts
   };

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   bclf_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   bclf_pkg::rsp_type rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [bclf_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [bclf_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // Model copy of the registers
   logic [bclf_pkg::RATIO_W-1:0] cfg_ratio   = bclf_pkg::DIVIDER_RATIO_RESET;
   logic [bclf_pkg::PCT_W-1:0]   cfg_low     = bclf_pkg::LOW_THRESHOLD_RESET;
   logic [bclf_pkg::PCT_W-1:0]   cfg_crit    = bclf_pkg::CRITICAL_THRESHOLD_RESET;
   logic                         cfg_shut_en = 1'b0;

   // Model copy of the filter state
   int unsigned acc_sum       = 0;
   int unsigned acc_count     = 0;
   int unsigned soc_pct       = 50;
   int unsigned soc_mv        = 0;
   int unsigned credit_tenths = CREDIT_FULL;
   logic        low_state     = 1'b0;
   logic        crit_state    = 1'b0;

   bclf_pkg::rsp_type expected_readings [$];
   int unsigned mismatches   = 0;
   int unsigned cycle_count  = 0;
   int unsigned words_sent   = 0;
   int unsigned burst_left   = 0;
   bit          hold_off_req = 1'b0;
   bit          on_charge    = 1'b0;

   battery_charge_level_filter_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(CLOCK_HALF) clock = ~clock;

   // Abort on a hang
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Linear interpolation along the discharge curve, truncating
   function automatic int unsigned curve_percent(input int unsigned mv);
      int unsigned hi_mv;
      int unsigned lo_mv;
      if (mv >= CURVE_MV[0]) return 100;
      if (mv <= CURVE_MV[CURVE_POINTS-1]) return 0;
      for (int i = 0; i + 1 < CURVE_POINTS; i++) begin
         hi_mv = CURVE_MV[i];
         lo_mv = CURVE_MV[i+1];
         if (mv <= hi_mv && mv >= lo_mv)
            return 100 - 5 * (i + 1) + (5 * (mv - lo_mv)) / (hi_mv - lo_mv);
      end
      return 0;
   endfunction

   // Advance the filter model by one accepted word; returns 1 with the
   // expected reading when the word closes a period.
   function automatic bit predict_reading(input bclf_pkg::req_type w,
                                          output bclf_pkg::rsp_type r);
      int unsigned mean_mv;
      int unsigned volt;
      int unsigned raw;
      int unsigned target;
      int unsigned diff;
      int unsigned stride;
      bit          up_ok;
      logic        old_low;
      r = '0;
      if (w.sample_valid && acc_count < ACC_DEPTH) begin
         acc_sum = (acc_sum + w.adc_millivolts > ACC_SUM_MAX) ? ACC_SUM_MAX
                                                             : acc_sum + w.adc_millivolts;
         acc_count++;
      end
      if (!w.last_sample) return 1'b0;

      if (acc_count == 0) begin
         // nothing usable: keep percent, voltage and flags
         r.sample_failed = 1'b1;
      end else begin
         mean_mv = acc_sum / acc_count;
         volt    = mean_mv * cfg_ratio;
         if (volt > MV_CEILING) volt = MV_CEILING;
         raw = curve_percent(volt);
         r.raw_percent = 7'(raw);
         if (w.mode) begin
            // initial load: take the table value as it is, flags untouched
            soc_mv        = volt;
            soc_pct       = raw;
            credit_tenths = CREDIT_FULL;
         end else begin
            target = raw;
            up_ok  = w.charging || w.charge_done;
            if (up_ok && target < soc_pct) target = soc_pct;
            else if (!up_ok && target > soc_pct) target = soc_pct;
            if (credit_tenths < CREDIT_FULL) credit_tenths++;
            if (target != soc_pct) begin
               diff   = target > soc_pct ? target - soc_pct : soc_pct - target;
               stride = diff < credit_tenths / 10 ? diff : credit_tenths / 10;
               target = target > soc_pct ? soc_pct + stride : soc_pct - stride;
               credit_tenths = stride * 10 >= credit_tenths ? 0
                                                            : credit_tenths - stride * 10;
            end
            old_low    = low_state;
            soc_mv     = volt;
            soc_pct    = target;
            low_state  = soc_pct <= cfg_low;
            crit_state = soc_pct <= cfg_crit;
            r.low_changed      = old_low != low_state;
            r.shutdown_request = crit_state && !w.charging && cfg_shut_en;
         end
      end
      acc_sum   = 0;
      acc_count = 0;
      r.percent          = 7'(soc_pct);
      r.battery_mv       = 17'(soc_mv);
      r.battery_low      = low_state;
      r.battery_critical = crit_state;
      return 1'b1;
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   // Compare every result word with the oldest outstanding reading
   always @(posedge clock) begin
      bclf_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_readings.size() == 0) begin
            $error("result word with no reading outstanding");
            mismatches++;
         end else begin
            want = expected_readings.pop_front();
            check_field("percent", 32'(want.percent), 32'(rsp_data.percent));
            check_field("raw_percent", 32'(want.raw_percent),
                        32'(rsp_data.raw_percent));
            check_field("battery_mv", 32'(want.battery_mv), 32'(rsp_data.battery_mv));
            check_field("battery_low", 32'(want.battery_low),
                        32'(rsp_data.battery_low));
            check_field("battery_critical", 32'(want.battery_critical),
                        32'(rsp_data.battery_critical));
            check_field("low_changed", 32'(want.low_changed),
                        32'(rsp_data.low_changed));
            check_field("shutdown_request", 32'(want.shutdown_request),
                        32'(rsp_data.shutdown_request));
            check_field("sample_failed", 32'(want.sample_failed),
                        32'(rsp_data.sample_failed));
         end
      end
   end

   // Result side: stall on a pattern of its own, and once hold off for a long
   // stretch so the block fills up and drops req_ready.
   initial begin : rsp_stall_pattern
      stall_style_type style;
      int              span;
      wait (reset == 1'b0);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         style = stall_style_type'($urandom_range(0, 3));
         span  = $urandom_range(10, 150);
         repeat (span) begin
            case (style)
               STALL_NONE:   rsp_ready <= 1'b1;
               STALL_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
               STALL_HEAVY:  rsp_ready <= ($urandom_range(0, 9) == 0);
               STALL_TOGGLE: rsp_ready <= !rsp_ready;
               default:      rsp_ready <= 1'b1;
            endcase
            @(posedge clock);
         end
      end
   end

   // Offer one word and hold it until taken; then either keep the burst going
   // or drop valid for a random gap and pick the next burst length.
   task automatic send_word(input bclf_pkg::req_type w, input bit typed,
                            input bclf_pkg::rsp_type typed_reading);
      bclf_pkg::rsp_type predicted;
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      if (predict_reading(w, predicted))
         expected_readings.push_back(typed ? typed_reading : predicted);
      words_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(0, 12);
      end
   endtask

   // Stop offering and wait until every reading has come back
   task automatic drain_readings();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_readings.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [bclf_pkg::CSR_IDX_W-1:0] idx,
                            input logic [bclf_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         bclf_pkg::CSR_DIVIDER_RATIO:      cfg_ratio   = data[bclf_pkg::RATIO_W-1:0];
         bclf_pkg::CSR_LOW_THRESHOLD:      cfg_low     = data[bclf_pkg::PCT_W-1:0];
         bclf_pkg::CSR_CRITICAL_THRESHOLD: cfg_crit    = data[bclf_pkg::PCT_W-1:0];
         bclf_pkg::CSR_SHUTDOWN_ENABLE:    cfg_shut_en = data[0];
         default: ;
      endcase
   endtask

   // Write all registers with junk in the unused upper bits, plus one write
   // to an unmapped index that must change nothing.
   task automatic apply_setting(input csr_setting_type s);
      drain_readings();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_reg(bclf_pkg::CSR_DIVIDER_RATIO,      {4'($urandom), s.ratio});
      write_reg(bclf_pkg::CSR_LOW_THRESHOLD,      {1'($urandom), s.low_pct});
      write_reg(bclf_pkg::CSR_CRITICAL_THRESHOLD, {1'($urandom), s.crit_pct});
      write_reg(bclf_pkg::CSR_SHUTDOWN_ENABLE,    {7'($urandom), s.shut_en});
      write_reg(3'(CSR_FIRST_UNUSED + $urandom_range(0, 3)), 8'($urandom));
      csr_valid <= 1'b0;
   endtask

   // One monitoring period: mostly a short run of samples around a voltage
   // on the curve, sometimes wild readings, long periods that overflow the
   // accumulator depth, or periods with no valid sample at all.
   task automatic run_period();
      int                pick;
      int                len;
      int                base;
      int                adc;
      bit                all_bad;
      bit                init_load;
      bclf_pkg::req_type w;
      pick = $urandom_range(0, 99);
      if (pick < 5)       len = $urandom_range(64, 70);
      else if (pick < 15) len = $urandom_range(9, 40);
      else                len = $urandom_range(1, 8);
      all_bad   = ($urandom_range(0, 19) == 0);
      init_load = ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 4) == 0) on_charge = !on_charge;
      if (cfg_ratio != 0 && $urandom_range(0, 4) != 0)
         base = $urandom_range(2900, 4300) / cfg_ratio;
      else
         base = $urandom_range(0, 16383);
      for (int k = 0; k < len; k++) begin
         adc = base + $urandom_range(0, 16) - 8;
         if (adc < 0) adc = 0;
         if (adc > 16383) adc = 16383;
         w.adc_millivolts = 14'(adc);
         w.sample_valid   = !all_bad && ($urandom_range(0, 9) != 0);
         w.last_sample    = (k == len - 1);
         // control fields on non-closing words are noise
         w.mode           = w.last_sample ? init_load : 1'($urandom);
         w.charging       = w.last_sample ? on_charge : 1'($urandom);
         w.charge_done    = ($urandom_range(0, 9) == 0);
         send_word(w, 1'b0, '0);
      end
   endtask

   initial begin : stimulus
      int              phase_start;
      csr_setting_type s;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table under reset register values
      for (int i = 0; i < DIRECTED_COUNT; i++)
         send_word(DIRECTED_ROWS[i].word, DIRECTED_ROWS[i].typed,
                   DIRECTED_ROWS[i].reading);

      for (int p = 0; p < PHASES; p++) begin
         if (p < FIXED_SETTINGS) begin
            s = PHASE_SETTINGS[p];
         end else begin
            s.ratio    = 4'($urandom_range(0, 15));
            s.low_pct  = 7'($urandom_range(0, 127));
            s.crit_pct = 7'($urandom_range(0, 127));
            s.shut_en  = 1'($urandom_range(0, 1));
         end
         apply_setting(s);
         // Long result-side hold-off while words keep coming
         if (p == 1) hold_off_req = 1'b1;
         phase_start = words_sent;
         while (words_sent - phase_start < WORDS_PER_PHASE) begin
            run_period();
            // now and then pause until every reading is back
            if ($urandom_range(0, 29) == 0) drain_readings();
         end
      end

      drain_readings();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_readings.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
